@@ sv/tprt_pkg.sv @@
// Shared types, constants and status codes for the two-peer room relay table.
package tprt_pkg;

  // Table size default
  localparam int ROOMS_DEFAULT = 16;

  // Packet length limits in bytes
  localparam logic [10:0] MIN_PACKET   = 11'd5;
  localparam logic [10:0] MAX_PACKET   = 11'd1504;
  localparam logic [10:0] HEADER_BYTES = 11'd4;

  // Whole seconds of a 32-bit ms value: (x * SEC_MAGIC) >> SEC_SHIFT == x / 1000
  localparam logic [28:0] SEC_MAGIC = 29'd274877907;
  localparam int          SEC_SHIFT = 38;
  localparam int          PROD_W    = 61;
  localparam int          SEC_W     = PROD_W - SEC_SHIFT;

  // Configuration register indexes
  localparam logic REG_ENABLE  = 1'b0;
  localparam logic REG_TIMEOUT = 1'b1;

  localparam logic [31:0] TIMEOUT_RESET = 32'd10000;

  // Result status codes
  localparam logic [2:0] ST_FORWARD    = 3'd0;
  localparam logic [2:0] ST_HELD       = 3'd1;
  localparam logic [2:0] ST_SHORT      = 3'd2;
  localparam logic [2:0] ST_ROOM_FULL  = 3'd3;
  localparam logic [2:0] ST_TABLE_FULL = 3'd4;
  localparam logic [2:0] ST_TICK       = 3'd5;
  localparam logic [2:0] ST_OFF        = 3'd6;

  localparam logic [4:0] COUNT_MAX = 5'd31;

  // Token that walks the row of cells, one cell per cycle
  typedef struct packed {
    logic        valid;
    logic        evict;   // eviction sweep, else room lookup
    logic [31:0] room;
    logic        hit;     // a used entry holds this room
    logic        free;    // a free entry was seen
    logic        pv0;
    logic [31:0] pa0;
    logic [15:0] pp0;
    logic        pv1;
    logic [31:0] pa1;
    logic [15:0] pp1;
    logic [4:0]  count;   // rooms evicted so far
  } tprt_token_t;

  // Update broadcast to the cell picked by the last lookup
  typedef struct packed {
    logic        valid;
    logic        to_free; // allocate the first free cell, else update the hit cell
    logic [31:0] room;
    logic [31:0] last_ms;
    logic        wr_en;   // register the sender in a peer slot
    logic        wr_slot;
    logic [31:0] addr;
    logic [15:0] port;
  } tprt_commit_t;

endpackage

@@ sv/two_peer_room_relay_table_unit.sv @@
// Top level of the two-peer room relay table: control, clock, row of room cells.
//
// Each request is a packet or a time tick, and gives exactly one result.
// A packet of 5 bytes or more walks a token through the row of ROOMS cells,
// one cell per cycle, to find its room or the lowest free entry, then the
// picked cell is updated. A tick that crosses a whole second also sweeps
// the row for idle rooms; short packets, and every request while the relay
// is off, skip the row. The next request is taken once the previous one
// has reached the output register, so the row walk sets the packet rate.
// Writing relay_enable clears the room table at once; the millisecond
// clock is kept.
module two_peer_room_relay_table_unit #(
  parameter int ROOMS = tprt_pkg::ROOMS_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  // Request channel
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [111:0] s_tdata,  // room_id, sender_addr, sender_port, packet_len, elapsed_ms
  input  logic         s_tuser,  // req_type
  // Result channel
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [63:0]  m_tdata,  // dest_addr, dest_port, payload_len, evicted_count
  output logic [2:0]   m_tuser,  // status
  // Configuration
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [31:0]  cfg_wdata
);
  import tprt_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_TMUL  = 3'd1;
  localparam logic [2:0] S_TCMP  = 3'd2;
  localparam logic [2:0] S_SWEEP = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  // Request fields
  logic        req_type;
  logic [31:0] in_room;
  logic [31:0] in_addr;
  logic [15:0] in_port;
  logic [10:0] in_len;
  logic [15:0] in_elapsed;

  assign req_type   = s_tuser;
  assign in_room    = s_tdata[31:0];
  assign in_addr    = s_tdata[63:32];
  assign in_port    = s_tdata[79:64];
  assign in_len     = s_tdata[90:80];
  assign in_elapsed = s_tdata[106:91];

  logic [2:0]        state;
  logic              relay_enable;
  logic [31:0]       timeout_ms;
  logic [31:0]       total_ms;
  logic [SEC_W-1:0]  sec;
  logic [PROD_W-1:0] prod;
  logic [SEC_W-1:0]  sec_new;
  logic              tbl_clear;

  // Packet held during the lookup
  logic [31:0] pk_addr;
  logic [15:0] pk_port;
  logic [10:0] pk_len;

  // Pending result
  logic [2:0]  res_status;
  logic [31:0] res_addr;
  logic [15:0] res_port;
  logic [10:0] res_len;
  logic [4:0]  res_count;

  tprt_token_t  chain [0:ROOMS];
  tprt_token_t  tok_end;
  tprt_token_t  tok_start;
  tprt_commit_t cmt;
  tprt_commit_t cmt_next;
  logic [ROOMS:0] tok_vld;

  logic        accept;
  logic        out_free;
  logic [2:0]  pk_status;
  logic        m0;
  logic        m1;
  logic        v0;
  logic        v1;
  logic        slot;
  logic        o_valid;
  logic [31:0] o_addr;
  logic [15:0] o_port;

  assign s_tready  = (state == S_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign tbl_clear = cfg_we && (cfg_index == REG_ENABLE);
  assign tok_end   = chain[ROOMS];
  assign sec_new   = prod[PROD_W-1:SEC_SHIFT];

  // Row of room cells
  for (genvar i = 0; i < ROOMS; i++) begin : g_cell
    tprt_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .tbl_clear  (tbl_clear),
      .total_ms   (total_ms),
      .timeout_ms (timeout_ms),
      .tok_in     (chain[i]),
      .tok_out    (chain[i+1]),
      .cmt        (cmt)
    );
  end

  for (genvar i = 0; i <= ROOMS; i++) begin : g_vld
    assign tok_vld[i] = chain[i].valid;
  end

  // Launch a lookup token for a packet, or a sweep token on a second crossing
  always_comb begin
    tok_start       = '0;
    tok_start.evict = (state == S_TCMP) && (sec_new != sec);
    tok_start.valid = tok_start.evict ||
                      (accept && relay_enable && !req_type && (in_len >= MIN_PACKET));
    tok_start.room  = in_room;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chain[0] <= '0;
    end else begin
      chain[0] <= tok_start;
    end
  end

  // Resolve the sender against the room's peer slots
  always_comb begin
    v0 = tok_end.hit && tok_end.pv0;
    v1 = tok_end.hit && tok_end.pv1;
    m0 = v0 && (tok_end.pa0 == pk_addr) && (tok_end.pp0 == pk_port);
    m1 = v1 && (tok_end.pa1 == pk_addr) && (tok_end.pp1 == pk_port);

    cmt_next         = '0;
    cmt_next.to_free = !tok_end.hit;
    cmt_next.room    = tok_end.room;
    cmt_next.last_ms = total_ms;
    cmt_next.addr    = pk_addr;
    cmt_next.port    = pk_port;
    slot             = 1'b0;
    pk_status        = ST_HELD;

    priority if (!tok_end.hit && !tok_end.free) begin
      pk_status = ST_TABLE_FULL;
    end else begin
      cmt_next.valid = 1'b1;
      priority if (m0) begin
        slot = 1'b0;
      end else if (m1) begin
        slot = 1'b1;
      end else if (!v0) begin
        slot           = 1'b0;
        cmt_next.wr_en = 1'b1;
      end else if (!v1) begin
        slot           = 1'b1;
        cmt_next.wr_en = 1'b1;
      end else begin
        pk_status = ST_ROOM_FULL;
      end
    end
    cmt_next.wr_slot = slot;

    o_valid = slot ? v0 : v1;
    o_addr  = slot ? tok_end.pa0 : tok_end.pa1;
    o_port  = slot ? tok_end.pp0 : tok_end.pp1;
    if ((pk_status == ST_HELD) && o_valid) begin
      pk_status = ST_FORWARD;
    end
  end

  // Issue the entry update once the lookup token leaves the row
  always_ff @(posedge clk) begin
    if (!rst && (state == S_SWEEP) && tok_end.valid && !tok_end.evict) begin
      cmt <= cmt_next;
    end else begin
      cmt <= '0;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      relay_enable <= 1'b0;
      timeout_ms   <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ENABLE:  relay_enable <= cfg_wdata[0];
        REG_TIMEOUT: timeout_ms   <= cfg_wdata;
        default:     ;
      endcase
    end
  end

  // Whole-second detection, one multiply then compare
  always_ff @(posedge clk) begin
    prod <= PROD_W'(total_ms) * PROD_W'(SEC_MAGIC);
  end

  // Result valid: raise on hand-off, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == S_DONE) && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Control sequence
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      total_ms <= '0;
      sec      <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            res_addr  <= '0;
            res_port  <= '0;
            res_len   <= '0;
            res_count <= '0;
            priority if (!relay_enable) begin
              res_status <= ST_OFF;
              state      <= S_DONE;
            end else if (req_type) begin
              total_ms <= total_ms + 32'(in_elapsed);
              state    <= S_TMUL;
            end else if (in_len < MIN_PACKET) begin
              res_status <= ST_SHORT;
              state      <= S_DONE;
            end else begin
              pk_addr <= in_addr;
              pk_port <= in_port;
              pk_len  <= (in_len > MAX_PACKET) ? MAX_PACKET : in_len;
              state   <= S_SWEEP;
            end
          end
        end
        S_TMUL: begin
          state <= S_TCMP;
        end
        S_TCMP: begin
          sec <= sec_new;
          if (sec_new != sec) begin
            state <= S_SWEEP;
          end else begin
            res_status <= ST_TICK;
            state      <= S_DONE;
          end
        end
        S_SWEEP: begin
          if (tok_end.valid) begin
            if (tok_end.evict) begin
              res_status <= ST_TICK;
              res_count  <= tok_end.count;
            end else begin
              res_status <= pk_status;
              if (pk_status == ST_FORWARD) begin
                res_addr <= o_addr;
                res_port <= o_port;
                res_len  <= pk_len - HEADER_BYTES;
              end
            end
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            m_tuser <= res_status;
            m_tdata <= {res_count, res_len, res_port, res_addr};
            state   <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  // Only one token walks the row at a time
  a_one_token: assert property (@(posedge clk) disable iff (rst) $onehot0(tok_vld))
    else $error("more than one token in the cell row");

  // A token leaves the row only while control waits for it
  a_end_in_sweep: assert property (@(posedge clk) disable iff (rst)
    tok_end.valid |-> (state == S_SWEEP))
    else $error("token left the row outside a sweep");

  // An entry update is issued together with its pending result
  a_cmt_done: assert property (@(posedge clk) disable iff (rst)
    cmt.valid |-> (state == S_DONE))
    else $error("entry update outside result hand-off");

  // A request while off goes straight to the result stage
  a_off_fast: assert property (@(posedge clk) disable iff (rst)
    (accept && !relay_enable) |=> (state == S_DONE) && (res_status == ST_OFF))
    else $error("request while off did not complete at once");
`endif

endmodule

@@ sv/tprt_cell.sv @@
// One room entry of the relay table: lookup, allocation, refresh and eviction.
module tprt_cell (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  tbl_clear,
  input  logic [31:0]           total_ms,
  input  logic [31:0]           timeout_ms,
  input  tprt_pkg::tprt_token_t  tok_in,
  output tprt_pkg::tprt_token_t  tok_out,
  input  tprt_pkg::tprt_commit_t cmt
);
  import tprt_pkg::*;

  logic        used;
  logic [31:0] room;
  logic [31:0] last_ms;
  logic        pv0;
  logic [31:0] pa0;
  logic [15:0] pp0;
  logic        pv1;
  logic [31:0] pa1;
  logic [15:0] pp1;
  logic        sel_hit;
  logic        sel_free;

  logic        lookup;
  logic        hit_here;
  logic        free_here;
  logic        evict_here;
  logic        mine;
  tprt_token_t tok_next;

  // Compare this entry against the passing token
  assign lookup     = tok_in.valid && !tok_in.evict;
  assign hit_here   = lookup && used && (room == tok_in.room) && !tok_in.hit;
  assign free_here  = lookup && !used && !tok_in.free;
  assign evict_here = tok_in.valid && tok_in.evict && used &&
                      ((total_ms - last_ms) > timeout_ms);
  assign mine       = cmt.valid && (cmt.to_free ? sel_free : sel_hit);

  always_comb begin
    tok_next = tok_in;
    if (hit_here) begin
      tok_next.hit = 1'b1;
      tok_next.pv0 = pv0;
      tok_next.pa0 = pa0;
      tok_next.pp0 = pp0;
      tok_next.pv1 = pv1;
      tok_next.pa1 = pa1;
      tok_next.pp1 = pp1;
    end
    if (free_here) begin
      tok_next.free = 1'b1;
    end
    if (evict_here && (tok_in.count != COUNT_MAX)) begin
      tok_next.count = tok_in.count + 5'd1;
    end
    if (rst) begin
      tok_next.valid = 1'b0;
    end
  end

  // Hand the token to the next cell
  always_ff @(posedge clk) begin
    tok_out <= tok_next;
  end

  // Remember whether this cell was picked by the lookup
  always_ff @(posedge clk) begin
    if (rst) begin
      sel_hit  <= 1'b0;
      sel_free <= 1'b0;
    end else if (lookup) begin
      sel_hit  <= hit_here;
      sel_free <= free_here;
    end
  end

  // Entry and peer valid bits
  always_ff @(posedge clk) begin
    if (rst || tbl_clear || evict_here) begin
      used <= 1'b0;
      pv0  <= 1'b0;
      pv1  <= 1'b0;
    end else if (mine) begin
      if (cmt.to_free) begin
        used <= 1'b1;
      end
      if (cmt.wr_en && !cmt.wr_slot) begin
        pv0 <= 1'b1;
      end else if (cmt.to_free) begin
        pv0 <= 1'b0;
      end
      if (cmt.wr_en && cmt.wr_slot) begin
        pv1 <= 1'b1;
      end else if (cmt.to_free) begin
        pv1 <= 1'b0;
      end
    end
  end

  // Entry payload, meaningful only while the matching valid bit is set
  always_ff @(posedge clk) begin
    if (mine) begin
      last_ms <= cmt.last_ms;
      if (cmt.to_free) begin
        room <= cmt.room;
      end
      if (cmt.wr_en && !cmt.wr_slot) begin
        pa0 <= cmt.addr;
        pp0 <= cmt.port;
      end
      if (cmt.wr_en && cmt.wr_slot) begin
        pa1 <= cmt.addr;
        pp1 <= cmt.port;
      end
    end
  end

endmodule
